// ===== sv/voronoi_color_mismatch_cost_core_defines.svh =====
// Assertion macros for the voronoi color mismatch cost core.
// Included by the files that carry concurrent assertions; no dependencies.
`ifndef VORONOI_COLOR_MISMATCH_COST_CORE_DEFINES_SVH
`define VORONOI_COLOR_MISMATCH_COST_CORE_DEFINES_SVH

// same-cycle implication
`define VCMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VCMC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/vcmc_pkg.sv =====
// Shared types and constants of the voronoi color mismatch cost core.
// No dependencies; imported by vcmc_mul, vcmc_div and the top level.
`timescale 1ns / 1ps
package vcmc_pkg;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	localparam logic [1:0] REG_WEIGHTED = 2'd0;
	localparam logic [1:0] REG_CELLS    = 2'd1;
	localparam logic [1:0] REG_STRIDE   = 2'd2;
	localparam logic [1:0] REG_PIXELS   = 2'd3;

	localparam int COORD_W = 20;
	localparam int WGT_W   = 16;
	localparam int COLOR_W = 17;
	localparam int SAMP_W  = 12;
	localparam int ACC_W   = 41;
	localparam int CNT_W   = 24;
	localparam int DIST_W  = 43;
	localparam int CMP_W   = 75;
	localparam int DVD_W   = 55;
	localparam int DVS_W   = 25;
	localparam int MUL_W   = 32;
	localparam int ENTRY_W = 2 * COORD_W + WGT_W + COLOR_W;

	localparam logic [COLOR_W-1:0] ONE_Q16  = 17'd65536;
	localparam logic [COLOR_W-1:0] HALF_Q16 = 17'd32768;
	localparam logic [ACC_W-1:0]   ACC_MAX  = '1;
	localparam logic [CNT_W-1:0]   CNT_MAX  = '1;

endpackage

// ===== sv/vcmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module vcmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/vcmc_mul.sv =====
// Shared 32x32 multiplier with registered product.
// Uses vcmc_pkg widths.
`timescale 1ns / 1ps
module vcmc_mul import vcmc_pkg::*; (
	input  logic                 clk,
	input  logic [MUL_W-1:0]     a,
	input  logic [MUL_W-1:0]     b,
	output logic [2*MUL_W-1:0]   prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end
endmodule

// ===== sv/vcmc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses vcmc_pkg widths.
`timescale 1ns / 1ps
module vcmc_div import vcmc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done_q,
	output logic [DVD_W-1:0] quo_q
);
	localparam int CW = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic [DVS_W:0]   rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DVD_W);
				rem_q <= '0;
				quo_q <= dividend;
				dvs_q <= divisor;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				rem_q <= fits ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], fits};
				if (cnt_q == CW'(1))
					done_q <= 1'b1;
			end
		end
	end
endmodule

// ===== sv/voronoi_color_mismatch_cost_core.sv =====
// Top level of the voronoi color mismatch cost core: sequencer, site store, cost state.
// Depends on vcmc_pkg, vcmc_ram, vcmc_mul, vcmc_div and the assertion macro header.
//
//  channel | direction | handshake         | word
//  in      | in        | in_valid/in_stall | operation, cell slot, site, sample fields
//  out     | out       | out_valid/out_stall | mismatch_cost, samples_seen
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Load: a site store write from idle. Sample: S_RD, S_DX, S_DY, S_W, S_M0 per scanned cell,
// S_M1, S_M2 also when weighted, then S_ACC; the single shared multiplier steps through dx^2, dy^2,
// w^2 and the wide product. Finish: S_F0, S_F1, S_F2, bit-serial divider (55 steps), S_FOUT.
// in_stall is high while a word is in work; the result register frees the out side.
// Reset clears control state, configuration and the cost state; the site store is not cleared.
`timescale 1ns / 1ps
`include "voronoi_color_mismatch_cost_core_defines.svh"
module voronoi_color_mismatch_cost_core import vcmc_pkg::*; #(
	parameter int MAX_CELLS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                operation,
	input  logic [5:0]                cell_slot,
	input  logic signed [COORD_W-1:0] site_x,
	input  logic signed [COORD_W-1:0] site_y,
	input  logic [WGT_W-1:0]          site_weight,
	input  logic [COLOR_W-1:0]        site_color,
	input  logic [SAMP_W-1:0]         sample_x,
	input  logic [SAMP_W-1:0]         sample_y,
	input  logic                      sample_class,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [COLOR_W-1:0]        mismatch_cost,
	output logic [CNT_W-1:0]          samples_seen,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [DVS_W-1:0]          cfg_data
);
	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CW = $clog2(MAX_CELLS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_DX, S_DY, S_W, S_M0, S_M1, S_M2, S_ACC,
		S_F0, S_F1, S_F2, S_F3, S_FOUT
	} state_t;

	state_t state_q;

	logic                 weighted_q;
	logic [6:0]           cells_q;
	logic [6:0]           stride_q;
	logic [DVS_W-1:0]     pixels_q;

	logic [ACC_W-1:0]     acc_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CW-1:0]        n_q;
	logic [CW-1:0]        idx_q;
	logic [COORD_W-1:0]   px_q;
	logic [COORD_W-1:0]   py_q;
	logic                 cls_q;
	logic                 have_q;
	logic [CMP_W-1:0]     best_q;
	logic [COLOR_W-1:0]   add_q;
	logic [DIST_W-1:0]    d_q;
	logic [MUL_W-1:0]     ww_q;
	logic [2*MUL_W-1:0]   p0_q;
	logic                 out_valid_q;
	logic [COLOR_W-1:0]   cost_q;
	logic [CNT_W-1:0]     seen_q;

	logic                 accept;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [ENTRY_W-1:0]   ram_rdata;
	logic [9:0]           slot_ext;
	logic signed [COORD_W-1:0] rx, ry;
	logic [WGT_W-1:0]     rw;
	logic [COLOR_W-1:0]   rc;
	logic signed [COORD_W+1:0] dx, dy;
	logic [COORD_W:0]     adx, ady;
	logic [MUL_W-1:0]     mul_a, mul_b;
	logic [2*MUL_W-1:0]   prod_q;
	logic [13:0]          s2;
	logic [CMP_W-1:0]     cmp_val;
	logic                 cmp_en;
	logic [COLOR_W-1:0]   cls_val;
	logic [COLOR_W-1:0]   diff;
	logic [ACC_W:0]       acc_sum;
	logic [31:0]          n_int;
	logic                 div_start;
	logic                 div_done;
	logic [DVD_W-1:0]     dividend;
	logic [DVD_W-1:0]     quo;
	logic [DVS_W-1:0]     divisor;
	logic                 out_free;
	logic                 out_set;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign mismatch_cost = cost_q;
	assign samples_seen  = seen_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_set   = state_q == S_FOUT && out_free;

	assign slot_ext  = 10'(cell_slot);
	assign ram_waddr = slot_ext[AW-1:0];
	assign ram_we    = accept && operation == OP_LOAD && 32'(cell_slot) < MAX_CELLS;

	vcmc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CELLS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({site_x, site_y, site_weight, site_color}),
		.re    (state_q == S_RD),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign {rx, ry, rw, rc} = ram_rdata;
	assign dx  = {{2{rx[COORD_W-1]}}, rx} - $signed({2'b00, px_q});
	assign dy  = {{2{ry[COORD_W-1]}}, ry} - $signed({2'b00, py_q});
	assign adx = dx[COORD_W+1] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
	assign ady = dy[COORD_W+1] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
	assign s2  = stride_q * stride_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_DX: begin
				mul_a = MUL_W'(adx);
				mul_b = MUL_W'(adx);
			end
			S_DY: begin
				mul_a = MUL_W'(ady);
				mul_b = MUL_W'(ady);
			end
			S_W: begin
				mul_a = MUL_W'(rw);
				mul_b = MUL_W'(rw);
			end
			S_M0: begin
				mul_a = d_q[MUL_W-1:0];
				mul_b = prod_q[MUL_W-1:0];
			end
			S_M1: begin
				mul_a = MUL_W'(d_q[DIST_W-1:MUL_W]);
				mul_b = ww_q;
			end
			S_F0: begin
				mul_a = acc_q[MUL_W-1:0];
				mul_b = MUL_W'(s2);
			end
			S_F1: begin
				mul_a = MUL_W'(acc_q[ACC_W-1:MUL_W]);
				mul_b = MUL_W'(s2);
			end
			default: ;
		endcase
	end

	vcmc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod_q));

	always_comb begin
		cmp_en  = 1'b0;
		cmp_val = CMP_W'(d_q);
		if (state_q == S_M0 && !weighted_q)
			cmp_en = 1'b1;
		if (state_q == S_M2) begin
			cmp_en  = 1'b1;
			cmp_val = {prod_q[DIST_W-1:0], {MUL_W{1'b0}}} + CMP_W'(p0_q);
		end
	end

	assign cls_val  = cls_q ? ONE_Q16 : '0;
	assign diff     = (cls_val > rc) ? cls_val - rc : rc - cls_val;
	assign acc_sum  = {1'b0, acc_q} + (ACC_W + 1)'(add_q);
	assign n_int    = (32'(cells_q) > MAX_CELLS) ? MAX_CELLS : 32'(cells_q);

	assign dividend  = {prod_q[DVD_W-MUL_W-1:0], {MUL_W{1'b0}}} + DVD_W'(p0_q);
	assign divisor   = (pixels_q == '0) ? DVS_W'(1) : pixels_q;
	assign div_start = state_q == S_F2;

	vcmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done_q   (div_done),
		.quo_q    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weighted_q <= 1'b0;
			cells_q    <= '0;
			stride_q   <= 7'd1;
			pixels_q   <= DVS_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WEIGHTED: weighted_q <= cfg_data[0];
				REG_CELLS:    cells_q    <= cfg_data[6:0];
				REG_STRIDE:   stride_q   <= cfg_data[6:0];
				REG_PIXELS:   pixels_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			cnt_q       <= '0;
			have_q      <= 1'b0;
			idx_q       <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_set)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (cmp_en && (!have_q || cmp_val < best_q)) begin
				have_q <= 1'b1;
				best_q <= cmp_val;
				add_q  <= diff;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (operation)
							OP_SAMPLE: begin
								px_q   <= {sample_x, 8'd0};
								py_q   <= {sample_y, 8'd0};
								cls_q  <= sample_class;
								have_q <= 1'b0;
								add_q  <= HALF_Q16;
								idx_q  <= '0;
								n_q    <= CW'(n_int);
								state_q <= (n_int == 0) ? S_ACC : S_RD;
							end
							OP_FINISH: state_q <= S_F0;
							default: ;
						endcase
					end
				end
				S_RD: state_q <= S_DX;
				S_DX: state_q <= S_DY;
				S_DY: begin
					d_q     <= DIST_W'(prod_q);
					state_q <= S_W;
				end
				S_W: begin
					d_q     <= d_q + DIST_W'(prod_q);
					state_q <= S_M0;
				end
				S_M0: begin
					ww_q <= prod_q[MUL_W-1:0];
					if (weighted_q)
						state_q <= S_M1;
					else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= (idx_q + 1'b1 == n_q) ? S_ACC : S_RD;
					end
				end
				S_M1: begin
					p0_q    <= prod_q;
					state_q <= S_M2;
				end
				S_M2: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= (idx_q + 1'b1 == n_q) ? S_ACC : S_RD;
				end
				S_ACC: begin
					acc_q <= acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
					if (cnt_q != CNT_MAX)
						cnt_q <= cnt_q + 1'b1;
					state_q <= S_IDLE;
				end
				S_F0: state_q <= S_F1;
				S_F1: begin
					p0_q    <= prod_q;
					state_q <= S_F2;
				end
				S_F2: state_q <= S_F3;
				S_F3: begin
					if (div_done)
						state_q <= S_FOUT;
				end
				S_FOUT: begin
					// quotient holds until the next divider start
					if (out_free) begin
						cost_q  <= (quo > DVD_W'(ONE_Q16)) ? ONE_Q16 : quo[COLOR_W-1:0];
						seen_q  <= cnt_q;
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`VCMC_ASSERT_IMP(a_have_before_acc, clk, arst_n, state_q == S_ACC && n_q != '0, have_q,
		"sample finished a scan without a winner")
	`VCMC_ASSERT_IMP(a_cost_range, clk, arst_n, out_valid_q, cost_q <= ONE_Q16,
		"cost above one")
	`VCMC_ASSERT_NXT(a_result_held, clk, arst_n, state_q == S_FOUT && out_valid_q && out_stall,
		out_valid_q && $stable(cost_q) && $stable(seen_q), "pending result overwritten")
	`VCMC_ASSERT_IMP(a_scan_bound, clk, arst_n, state_q == S_RD, idx_q < n_q,
		"scan index past cell count")
endmodule
